@@ design/u16u8_pkg.sv @@
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and UTF-8 byte functions for the UTF-16 to UTF-8
// transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int unsigned UnitW   = 16;
  localparam int unsigned CpW     = 21;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned HeldW   = 10;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic [UnitW-1:0] HighFirst = 16'hD800;
  localparam logic [UnitW-1:0] HighLast  = 16'hDBFF;
  localparam logic [UnitW-1:0] LowFirst  = 16'hDC00;
  localparam logic [UnitW-1:0] LowLast   = 16'hDFFF;
  localparam logic [CpW-1:0]   CpRepl    = 21'h00FFFD;
  localparam logic [CpW-1:0]   CpSuppBase = 21'h010000;
  localparam logic [CpW-1:0]   Cp1Max    = 21'h00007F;
  localparam logic [CpW-1:0]   Cp2Max    = 21'h0007FF;
  localparam logic [CpW-1:0]   Cp3Max    = 21'h00FFFF;

  localparam logic [ByteW-1:0] LeadTwo   = 8'hC0;
  localparam logic [ByteW-1:0] LeadThree = 8'hE0;
  localparam logic [ByteW-1:0] LeadFour  = 8'hF0;
  localparam logic [ByteW-1:0] ContMark  = 8'h80;

  // Byte count of a sequence minus one
  typedef enum logic [1:0] {
    LEN_ONE   = 2'd0,
    LEN_TWO   = 2'd1,
    LEN_THREE = 2'd2,
    LEN_FOUR  = 2'd3
  } seq_len_e;

  // One queued job: an optional U+FFFD for a dropped high surrogate, then an
  // optional main code point.
  typedef struct packed {
    logic           pre_repl;
    logic           has_main;
    logic           fin;
    logic [CpW-1:0] cp;
  } job_t;

  function automatic seq_len_e cp_len(input logic [CpW-1:0] cp);
    seq_len_e len;
    if (cp <= Cp1Max) begin
      len = LEN_ONE;
    end else if (cp <= Cp2Max) begin
      len = LEN_TWO;
    end else if (cp <= Cp3Max) begin
      len = LEN_THREE;
    end else begin
      len = LEN_FOUR;
    end
    return len;
  endfunction

  function automatic logic [ByteW-1:0] cont_byte(input logic [5:0] bits);
    return ContMark | {2'b00, bits};
  endfunction

  // Byte number idx (from 0) of the UTF-8 form of cp
  function automatic logic [ByteW-1:0] cp_byte(input logic [CpW-1:0] cp,
                                                input logic [1:0]     idx);
    logic [ByteW-1:0] b;
    b = cp[7:0];
    case (cp_len(cp))
      LEN_ONE: begin
        b = cp[7:0];
      end
      LEN_TWO: begin
        b = (idx == 2'd0) ? (LeadTwo | {3'b000, cp[10:6]}) : cont_byte(cp[5:0]);
      end
      LEN_THREE: begin
        case (idx)
          2'd0:    b = LeadThree | {4'b0000, cp[15:12]};
          2'd1:    b = cont_byte(cp[11:6]);
          default: b = cont_byte(cp[5:0]);
        endcase
      end
      LEN_FOUR: begin
        case (idx)
          2'd0:    b = LeadFour | {5'b00000, cp[20:18]};
          2'd1:    b = cont_byte(cp[17:12]);
          2'd2:    b = cont_byte(cp[11:6]);
          default: b = cont_byte(cp[5:0]);
        endcase
      end
      default: begin
        b = cp[7:0];
      end
    endcase
    return b;
  endfunction

endpackage

@@ design/u16u8_if.sv @@
// ----------------------------------------------------------------------------
// u16u8 channel interfaces
// Valid/ready channels for UTF-16 code units in and UTF-8 bytes out.
// ----------------------------------------------------------------------------
interface u16u8_unit_if;
  logic                          valid;
  logic                          ready;
  logic [u16u8_pkg::UnitW-1:0]   code_unit;
  logic                          final_unit;

  modport source (output valid, output code_unit, output final_unit, input ready);
  modport sink   (input valid, input code_unit, input final_unit, output ready);
endinterface

interface u16u8_byte_if;
  logic                          valid;
  logic                          ready;
  logic [u16u8_pkg::ByteW-1:0]   utf8_byte;
  logic                          run_last;
  logic                          text_end;

  modport source (output valid, output utf8_byte, output run_last, output text_end,
                  input ready);
  modport sink   (input valid, input utf8_byte, input run_last, input text_end,
                  output ready);
endinterface

@@ design/u16u8_front.sv @@
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates and turns each unit into a job.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [u16u8_pkg::UnitW-1:0] code_unit_i,
  input  logic                   final_unit_i,
  output logic                   in_ready_o,
  input  logic                   q_ready_i,
  output logic                   push_o,
  output u16u8_pkg::job_t        job_o
);

  logic [u16u8_pkg::HeldW-1:0] held_q, held_d;
  logic                        held_valid_q, held_valid_d;
  logic                        is_high, is_low, accept;
  logic [u16u8_pkg::CpW-1:0]   pair_cp;

  assign is_high = (code_unit_i >= u16u8_pkg::HighFirst) &&
                   (code_unit_i <= u16u8_pkg::HighLast);
  assign is_low  = (code_unit_i >= u16u8_pkg::LowFirst) &&
                   (code_unit_i <= u16u8_pkg::LowLast);
  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;

  assign pair_cp = u16u8_pkg::CpSuppBase + {1'b0, held_q, code_unit_i[9:0]};

  always_comb begin
    job_o.fin      = final_unit_i;
    job_o.pre_repl = 1'b0;
    job_o.has_main = 1'b1;
    job_o.cp       = {5'd0, code_unit_i};
    if (held_valid_q && is_low) begin
      job_o.cp = pair_cp;
    end else begin
      job_o.pre_repl = held_valid_q;
      if (is_high) begin
        job_o.has_main = final_unit_i;
        job_o.cp       = u16u8_pkg::CpRepl;
      end else if (is_low) begin
        job_o.cp = u16u8_pkg::CpRepl;
      end
    end
  end

  // Drop jobs with no bytes: a fresh high surrogate that is only held
  assign push_o = accept && (job_o.pre_repl || job_o.has_main);

  always_comb begin
    held_d       = held_q;
    held_valid_d = held_valid_q;
    if (accept) begin
      held_d       = code_unit_i[9:0];
      held_valid_d = is_high && !final_unit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      held_valid_q <= 1'b0;
    end else begin
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
    end
  end

endmodule

@@ design/u16u8_fifo.sv @@
// ----------------------------------------------------------------------------
// u16u8_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module u16u8_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u16u8_pkg::job_t push_data_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output u16u8_pkg::job_t data_o
);

  u16u8_pkg::job_t                  mem_q [u16u8_pkg::QDepth];
  logic [u16u8_pkg::QPtrW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [u16u8_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign ready_o = cnt_q != u16u8_pkg::QCntW'(u16u8_pkg::QDepth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ design/u16u8_back.sv @@
// ----------------------------------------------------------------------------
// u16u8_back
// Walks each job byte by byte into a registered output stage.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  u16u8_pkg::job_t             q_data_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [u16u8_pkg::ByteW-1:0] utf8_byte_o,
  output logic                        run_last_o,
  output logic                        text_end_o
);

  u16u8_pkg::job_t              job_q, job_d;
  logic                         busy_q, busy_d;
  logic                         in_pre_q, in_pre_d;
  logic [1:0]                   idx_q, idx_d;
  logic                         out_valid_q, out_valid_d;
  logic [u16u8_pkg::ByteW-1:0]  byte_q, byte_d;
  logic                         run_last_q, run_last_d;
  logic                         text_end_q, text_end_d;

  logic [u16u8_pkg::CpW-1:0]    seg_cp;
  logic                         seg_last, job_last, advance;

  assign seg_cp   = in_pre_q ? u16u8_pkg::CpRepl : job_q.cp;
  assign seg_last = idx_q == 2'(u16u8_pkg::cp_len(seg_cp));
  assign job_last = seg_last && (!in_pre_q || !job_q.has_main);
  assign advance  = busy_q && (!out_valid_q || out_ready_i);
  assign pop_o    = q_valid_i && (!busy_q || (advance && job_last));

  always_comb begin
    job_d       = job_q;
    busy_d      = busy_q;
    in_pre_d    = in_pre_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    byte_d      = byte_q;
    run_last_d  = run_last_q;
    text_end_d  = text_end_q;

    if (advance) begin
      out_valid_d = 1'b1;
      byte_d      = u16u8_pkg::cp_byte(seg_cp, idx_q);
      run_last_d  = job_last;
      text_end_d  = job_last && job_q.fin;
      if (seg_last) begin
        // Leave the replacement prefix for the main code point
        in_pre_d = 1'b0;
        idx_d    = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
      if (job_last) begin
        busy_d = 1'b0;
      end
    end

    if (pop_o) begin
      job_d    = q_data_i;
      busy_d   = 1'b1;
      in_pre_d = q_data_i.pre_repl;
      idx_d    = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    byte_q     <= byte_d;
    run_last_q <= run_last_d;
    text_end_q <= text_end_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      in_pre_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      in_pre_q    <= in_pre_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign utf8_byte_o = byte_q;
  assign run_last_o  = run_last_q;
  assign text_end_o  = text_end_q;

endmodule

@@ design/utf16_to_utf8_transcoder_top.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_top
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing and U+FFFD
// replacement of unpaired surrogates.
// ----------------------------------------------------------------------------
// Each item on unit_i is one UTF-16 code unit; final_unit marks the last unit
// of a text. The block sends the UTF-8 bytes of the text on byte_o, one byte
// per cycle while byte_o is ready, with run_last on the last byte a unit
// causes and text_end on the last byte of the text. A high surrogate is held
// until the next unit: a low surrogate completes it into a four-byte sequence,
// anything else turns it into U+FFFD (EF BF BD) ahead of that unit's own
// bytes. A lone low surrogate, or a high surrogate that ends the text, becomes
// U+FFFD. A unit produces one to six bytes (three for most BMP text, none for
// a newly held high surrogate); the back end's byte walker loads them one per
// cycle into the output register unless byte_o stalls. The front end takes a
// unit every cycle while its four-entry job queue has room, so short bursts
// of input are absorbed while output is stalled. An accepted unit passes the
// job queue and the back end's job register before its first byte is loaded.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  u16u8_unit_if.sink          unit_i,
  u16u8_byte_if.source        byte_o
);

  // Job hand-off between front and back
  u16u8_pkg::job_t push_job, pop_job;
  logic            push, q_ready, q_valid, pop;

  // Front: classify units, hold high surrogates, build one job per unit
  u16u8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (unit_i.valid),
    .code_unit_i  (unit_i.code_unit),
    .final_unit_i (unit_i.final_unit),
    .in_ready_o   (unit_i.ready),
    .q_ready_i    (q_ready),
    .push_o       (push),
    .job_o        (push_job)
  );

  // Queue: decouple unit intake from byte output
  u16u8_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (pop_job)
  );

  // Back: emit the bytes of each job in order through the output register
  u16u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_job),
    .pop_o       (pop),
    .out_valid_o (byte_o.valid),
    .out_ready_i (byte_o.ready),
    .utf8_byte_o (byte_o.utf8_byte),
    .run_last_o  (byte_o.run_last),
    .text_end_o  (byte_o.text_end)
  );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-16 to UTF-8 transcoder. A scoreboard
// predicts the UTF-8 bytes of each accepted code unit, including surrogate
// pairing and U+FFFD replacement. Every byte leaving the block is checked in
// order, under several mixes of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module testbench;

  // One predicted output byte with its two markers
  typedef struct packed {
    logic [u16u8_pkg::ByteW-1:0] octet;
    logic                        run_last;
    logic                        text_end;
  } utf8_out_t;

  // Tracks the held high surrogate and the bytes still owed by the block.
  class utf8_scoreboard;
    utf8_out_t                   want_q[$];
    logic [u16u8_pkg::HeldW-1:0] held_bits;
    logic                        held_live;
    int                          mismatches;
    int                          units_noted;
    int                          bytes_checked;
    int                          pairs_formed;
    int                          repl_made;
    int                          texts_closed;

    function new();
      held_bits     = '0;
      held_live     = 1'b0;
      mismatches    = 0;
      units_noted   = 0;
      bytes_checked = 0;
      pairs_formed  = 0;
      repl_made     = 0;
      texts_closed  = 0;
    endfunction

    // Queue one predicted byte behind the others
    function void add_byte(input utf8_out_t o);
      want_q.insert(want_q.size(), o);
    endfunction

    // Append the UTF-8 form of one code point, markers cleared
    function void emit_cp(input logic [u16u8_pkg::CpW-1:0] cp);
      utf8_out_t o;
      o.run_last = 1'b0;
      o.text_end = 1'b0;
      if (cp == u16u8_pkg::CpRepl) begin
        repl_made++;
      end
      if (cp <= u16u8_pkg::Cp1Max) begin
        o.octet = cp[7:0];
        add_byte(o);
      end else if (cp <= u16u8_pkg::Cp2Max) begin
        o.octet = u16u8_pkg::LeadTwo | {3'b000, cp[10:6]};
        add_byte(o);
        o.octet = u16u8_pkg::ContMark | {2'b00, cp[5:0]};
        add_byte(o);
      end else if (cp <= u16u8_pkg::Cp3Max) begin
        o.octet = u16u8_pkg::LeadThree | {4'b0000, cp[15:12]};
        add_byte(o);
        o.octet = u16u8_pkg::ContMark | {2'b00, cp[11:6]};
        add_byte(o);
        o.octet = u16u8_pkg::ContMark | {2'b00, cp[5:0]};
        add_byte(o);
      end else begin
        o.octet = u16u8_pkg::LeadFour | {5'b00000, cp[20:18]};
        add_byte(o);
        o.octet = u16u8_pkg::ContMark | {2'b00, cp[17:12]};
        add_byte(o);
        o.octet = u16u8_pkg::ContMark | {2'b00, cp[11:6]};
        add_byte(o);
        o.octet = u16u8_pkg::ContMark | {2'b00, cp[5:0]};
        add_byte(o);
      end
    endfunction

    // Predict the bytes that one accepted code unit completes
    function void note_unit(input logic [u16u8_pkg::UnitW-1:0] cu, input logic fin);
      logic      is_high;
      logic      is_low;
      int        owed_before;
      utf8_out_t last;
      is_high     = (cu >= u16u8_pkg::HighFirst) && (cu <= u16u8_pkg::HighLast);
      is_low      = (cu >= u16u8_pkg::LowFirst) && (cu <= u16u8_pkg::LowLast);
      owed_before = want_q.size();
      units_noted++;
      if (held_live && is_low) begin
        emit_cp(u16u8_pkg::CpSuppBase + {1'b0, held_bits, cu[9:0]});
        pairs_formed++;
        held_live = 1'b0;
        held_bits = '0;
      end else begin
        if (held_live) begin
          emit_cp(u16u8_pkg::CpRepl);
          held_live = 1'b0;
          held_bits = '0;
        end
        if (is_high && !fin) begin
          held_bits = cu[9:0];
          held_live = 1'b1;
        end else if (is_high || is_low) begin
          emit_cp(u16u8_pkg::CpRepl);
        end else begin
          emit_cp({5'b00000, cu});
        end
      end
      if (fin) begin
        texts_closed++;
      end
      // Mark the last byte of this unit's run
      if (want_q.size() > owed_before) begin
        last          = want_q.pop_back();
        last.run_last = 1'b1;
        last.text_end = fin;
        add_byte(last);
      end
    endfunction

    // Compare one accepted byte with the oldest prediction
    function void check_byte(input logic [u16u8_pkg::ByteW-1:0] b, input logic rl,
                             input logic te);
      utf8_out_t want;
      bytes_checked++;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected byte %h run_last %b text_end %b", $time, b, rl, te);
        mismatches++;
        return;
      end
      want = want_q.pop_front();
      if (b !== want.octet || rl !== want.run_last || te !== want.text_end) begin
        $display("%0t: byte mismatch, expected %h/%b/%b, got %h/%b/%b", $time,
                 want.octet, want.run_last, want.text_end, b, rl, te);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  u16u8_unit_if unit_if ();
  u16u8_byte_if byte_if ();

  utf16_to_utf8_transcoder_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .unit_i (unit_if),
    .byte_o (byte_if)
  );

  utf8_scoreboard sb;

  // Percent chances of a sender idle cycle and a receiver stall cycle
  int unsigned gap_pct;
  int unsigned stall_pct;

  // 10-unit clock period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hard stop far beyond the slowest correct run
  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

  // Receiver: check each accepted byte, then pick next cycle's ready.
  // Sample at the edge, before the block's registers update.
  initial begin
    byte_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && byte_if.valid === 1'b1 && byte_if.ready === 1'b1) begin
        sb.check_byte(byte_if.utf8_byte, byte_if.run_last, byte_if.text_end);
      end
      byte_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offer one code unit, idle at random first, and hold it until accepted.
  // Called at a clock edge; valid gets exactly one assignment per edge.
  task automatic send_unit(input logic [u16u8_pkg::UnitW-1:0] cu, input logic fin);
    while ($urandom_range(0, 99) < gap_pct) begin
      unit_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    unit_if.valid      <= 1'b1;
    unit_if.code_unit  <= cu;
    unit_if.final_unit <= fin;
    do begin
      @(posedge clk_i);
    end while (unit_if.ready !== 1'b1);
    sb.note_unit(cu, fin);
  endtask

  // Drop valid and hold off until every predicted byte has come out
  task automatic drain_bytes();
    unit_if.valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (sb.want_q.size() != 0);
  endtask

  // Random text: mostly well-formed characters and surrogate pairs with
  // random content, the rest lone or broken surrogates and raw noise.
  task automatic random_text(input int n_items);
    int                          made;
    int unsigned                 kind;
    logic [u16u8_pkg::UnitW-1:0] cu;
    logic                        fin;
    made = 0;
    while (made < n_items) begin
      kind = $urandom_range(0, 99);
      fin  = ($urandom_range(0, 7) == 0);
      if (kind < 25) begin
        cu = 16'($urandom_range(0, 16'h007F));
      end else if (kind < 40) begin
        cu = 16'($urandom_range(16'h0080, 16'h07FF));
      end else if (kind < 60) begin
        cu = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(16'h0800, 16'hD7FF))
                                         : 16'($urandom_range(16'hE000, 16'hFFFF));
      end else if (kind < 85) begin
        // Well-formed pair: high never final, low may close the text
        send_unit(16'($urandom_range(u16u8_pkg::HighFirst, u16u8_pkg::HighLast)), 1'b0);
        made++;
        cu = 16'($urandom_range(u16u8_pkg::LowFirst, u16u8_pkg::LowLast));
      end else if (kind < 92) begin
        cu = 16'($urandom_range(0, 16'hFFFF));
        fin = 1'($urandom_range(0, 1));
      end else begin
        // Lone surrogate of either kind, often a high one ending the text
        cu = 16'($urandom_range(u16u8_pkg::HighFirst, u16u8_pkg::LowLast));
        fin = 1'($urandom_range(0, 1));
      end
      send_unit(cu, fin);
      made++;
    end
    // Close the text so nothing stays held across phases
    send_unit(16'($urandom_range(16'h0020, 16'h007E)), 1'b1);
  endtask

  initial begin
    int p;
    sb        = new();
    gap_pct   = 0;
    stall_pct = 0;
    rst_ni             <= 1'b0;
    unit_if.valid      <= 1'b0;
    unit_if.code_unit  <= '0;
    unit_if.final_unit <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: encoding length boundaries and every surrogate case
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hD7FF, 1'b0);
    send_unit(16'hE000, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    // lowest and highest supplementary code point, text ending on the low half
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    // lone low surrogate
    send_unit(16'hDC00, 1'b0);
    // held high followed by a plain character
    send_unit(16'hD83D, 1'b0);
    send_unit(16'h0041, 1'b0);
    // held high followed by a high that ends the text: two replacements
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDBFF, 1'b1);
    // held high replaced by another high, which then pairs
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    // high surrogate alone ending the text, then a final lone low
    send_unit(16'hDBFF, 1'b1);
    send_unit(16'hDFFF, 1'b1);
    send_unit(16'hFFFD, 1'b0);
    send_unit(16'h0041, 1'b1);

    // Hold the sender until the block has emptied
    drain_bytes();

    // Random phases: no idling, sender idle, receiver stall, both light
    for (p = 0; p < 4; p++) begin
      case (p)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 81;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 81;
        end
        default: begin
          gap_pct = 6;
          stall_pct = 6;
        end
      endcase
      random_text(19);
      drain_bytes();
    end

    // Let any stray byte show up before judging
    repeat (20) @(posedge clk_i);

    $display("Covered %0d code units and %0d bytes: %0d surrogate pairs, %0d U+FFFD,",
             sb.units_noted, sb.bytes_checked, sb.pairs_formed, sb.repl_made);
    $display("%0d texts closed, over four sender idle / receiver stall mixes.",
             sb.texts_closed);
    if (sb.mismatches == 0 && sb.want_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
